// File: rtl/core/point_segment_distance_3d_core_macros.svh
// ----------------------------------------------------------------------------
// point segment distance assertion macros
// shared assertion forms for the distance core checks
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_3D_CORE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_3D_CORE_MACROS_SVH

// check sampled on clk, ignored while rst_n is low
`define PSD3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psd3 check failed");

// check sampled on clk, active through reset
`define PSD3_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("psd3 reset check failed");

`endif

// File: rtl/core/psd3_pkg.sv
// ----------------------------------------------------------------------------
// psd3_pkg
// widths, codes and pipeline records of the point to segment distance core
// ----------------------------------------------------------------------------
`default_nettype none

package psd3_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 18;
  localparam int DIST_WIDTH  = 19;
  localparam int T_WIDTH     = 24;

  // derived arithmetic widths
  localparam int DFW    = COORD_WIDTH + 1;       // coordinate difference
  localparam int PW     = 2 * DFW;               // signed product
  localparam int SUMW   = PW + 2;                // sum of three products
  localparam int SQW    = 2 * COORD_WIDTH + 2;   // squared length, |dot|
  localparam int XW     = 2 * COORD_WIDTH + 1;   // cross component magnitude
  localparam int LB     = (XW + 1) / 2;          // low split of cross term
  localparam int HB     = XW - LB;               // high split of cross term
  localparam int PRW    = 2 * XW + 2;            // squared cross product norm
  localparam int TNW    = SQW + FRAC_BITS;       // t dividend
  localparam int TCW    = SQW + T_WIDTH;         // t divisor compare width
  localparam int TSHIFT = T_WIDTH - FRAC_BITS;
  localparam int OVW    = SQW + TSHIFT;
  localparam int QB     = SQW;                   // quotient bits of perp / len2
  localparam int NDIV   = QB;                    // divider stages
  localparam int RB     = SQW / 2;               // root bits
  localparam int RMW    = SQW + 2;               // root remainder

  // port packing
  localparam int IN_W        = 9 * COORD_WIDTH;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = DIST_WIDTH + T_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  // region codes
  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_BEFORE   = 2'd1;
  localparam logic [1:0] REGION_BEYOND   = 2'd2;

  localparam logic [T_WIDTH-1:0] T_MAX     = {1'b0, {(T_WIDTH-1){1'b1}}};
  localparam logic [T_WIDTH-1:0] T_NEG_MAG = {1'b1, {(T_WIDTH-1){1'b0}}};

  // control carried from the classify stage to the divider
  typedef struct packed {
    logic [SQW-1:0] len2;
    logic [SQW-1:0] alt;
    logic [TNW-1:0] tnum;
    logic           use_perp;
    logic           dneg;
    logic           tovf;
    logic [1:0]     region;
    logic           degen;
  } ctl_t;

  // divider stage record
  typedef struct packed {
    logic [PRW-1:0]     prem;
    logic [QB-1:0]      pq;
    logic [TNW-1:0]     trem;
    logic [T_WIDTH-1:0] tq;
    logic [SQW-1:0]     len2;
    logic [SQW-1:0]     alt;
    logic               use_perp;
    logic               dneg;
    logic               tovf;
    logic [1:0]         region;
    logic               degen;
  } div_t;

  // square root stage record
  typedef struct packed {
    logic [RMW-1:0]     rem;
    logic [RB-1:0]      root;
    logic [T_WIDTH-1:0] tq;
    logic               dneg;
    logic               tovf;
    logic [1:0]         region;
    logic               degen;
  } sqr_t;

endpackage

`default_nettype wire

// File: rtl/core/point_segment_distance_3d_core.sv
// path: stages a to g, the divider, the root select, the root stages and the output register
// throughput: one request per cycle while the output is not stalled, through the 38 step
//   restoring divider and the 19 step root, one quotient or root bit per register stage
// a stalled output holds the whole pipeline, nothing is dropped
// reset: synchronous active low rst_n clears all valid bits, no data reset
// ----------------------------------------------------------------------------
// point_segment_distance_3d_core
// distance from a 3d point to a segment and the projection parameter t
// ----------------------------------------------------------------------------
`default_nettype none

module point_segment_distance_3d_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
  input  wire logic [psd3_pkg::IN_TDATA_W-1:0]    in_tdata,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // distance, param_t
  output      logic [psd3_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // region, degenerate
  output      logic [psd3_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  localparam int CW   = psd3_pkg::COORD_WIDTH;
  localparam int DFW  = psd3_pkg::DFW;
  localparam int PW   = psd3_pkg::PW;
  localparam int SUMW = psd3_pkg::SUMW;
  localparam int SQW  = psd3_pkg::SQW;
  localparam int XW   = psd3_pkg::XW;
  localparam int LB   = psd3_pkg::LB;
  localparam int HB   = psd3_pkg::HB;
  localparam int PRW  = psd3_pkg::PRW;
  localparam int TNW  = psd3_pkg::TNW;
  localparam int TCW  = psd3_pkg::TCW;
  localparam int TW   = psd3_pkg::T_WIDTH;
  localparam int FB   = psd3_pkg::FRAC_BITS;
  localparam int TSH  = psd3_pkg::TSHIFT;
  localparam int OVW  = psd3_pkg::OVW;
  localparam int QB   = psd3_pkg::QB;
  localparam int NDIV = psd3_pkg::NDIV;
  localparam int RB   = psd3_pkg::RB;
  localparam int RMW  = psd3_pkg::RMW;
  localparam int DW   = psd3_pkg::DIST_WIDTH;

  logic en;

  logic                         out_vld_r;
  logic [DW-1:0]                dist_r;
  logic [TW-1:0]                t_r;
  logic [1:0]                   region_r;
  logic                         degen_r;

  // whole pipeline advances unless the output request is held
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------- stage a
  // coordinate differences v = p - s, d = e - s, w = p - e
  logic                  a_vld_r;
  logic signed [DFW-1:0] v_a_r [3];
  logic signed [DFW-1:0] d_a_r [3];
  logic signed [DFW-1:0] w_a_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_diff
    logic [CW-1:0] p_c;
    logic [CW-1:0] s_c;
    logic [CW-1:0] e_c;
    assign p_c = in_tdata[i*CW +: CW];
    assign s_c = in_tdata[(3+i)*CW +: CW];
    assign e_c = in_tdata[(6+i)*CW +: CW];
    always_ff @(posedge clk) begin
      if (en) begin
        v_a_r[i] <= {p_c[CW-1], p_c} - {s_c[CW-1], s_c};
        d_a_r[i] <= {e_c[CW-1], e_c} - {s_c[CW-1], s_c};
        w_a_r[i] <= {p_c[CW-1], p_c} - {e_c[CW-1], e_c};
      end
    end
  end

  // ---------------------------------------------------------------- stage b
  // all component products
  logic                 b_vld_r;
  logic signed [PW-1:0] vd_b_r [3];
  logic signed [PW-1:0] dd_b_r [3];
  logic signed [PW-1:0] vv_b_r [3];
  logic signed [PW-1:0] ww_b_r [3];
  logic signed [PW-1:0] xa_b_r [3];
  logic signed [PW-1:0] xb_b_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        vd_b_r[i] <= v_a_r[i] * d_a_r[i];
        dd_b_r[i] <= d_a_r[i] * d_a_r[i];
        vv_b_r[i] <= v_a_r[i] * v_a_r[i];
        ww_b_r[i] <= w_a_r[i] * w_a_r[i];
        // cross product v x d, component i
        xa_b_r[i] <= v_a_r[(i+1)%3] * d_a_r[(i+2)%3];
        xb_b_r[i] <= v_a_r[(i+2)%3] * d_a_r[(i+1)%3];
      end
    end
  end

  // ---------------------------------------------------------------- stage c
  // dot product, squared lengths and cross components
  logic                   c_vld_r;
  logic signed [SUMW-1:0] dot_c_r;
  logic [SQW-1:0]         len2_c_r;
  logic [SQW-1:0]         vv_c_r;
  logic [SQW-1:0]         ww_c_r;
  logic signed [PW:0]     xs_c_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_c_r  <= SUMW'(vd_b_r[0]) + SUMW'(vd_b_r[1]) + SUMW'(vd_b_r[2]);
      len2_c_r <= SQW'(SUMW'(dd_b_r[0]) + SUMW'(dd_b_r[1]) + SUMW'(dd_b_r[2]));
      vv_c_r   <= SQW'(SUMW'(vv_b_r[0]) + SUMW'(vv_b_r[1]) + SUMW'(vv_b_r[2]));
      ww_c_r   <= SQW'(SUMW'(ww_b_r[0]) + SUMW'(ww_b_r[1]) + SUMW'(ww_b_r[2]));
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross
    always_ff @(posedge clk) begin
      if (en) begin
        xs_c_r[i] <= (PW+1)'(xa_b_r[i]) - (PW+1)'(xb_b_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage d
  // magnitudes
  logic           d_vld_r;
  logic           dneg_d_r;
  logic [SQW-1:0] dotm_d_r;
  logic [SQW-1:0] len2_d_r;
  logic [SQW-1:0] vv_d_r;
  logic [SQW-1:0] ww_d_r;
  logic [XW-1:0]  xm_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg_d_r <= dot_c_r[SUMW-1];
      dotm_d_r <= dot_c_r[SUMW-1] ? SQW'(-dot_c_r) : SQW'(dot_c_r);
      len2_d_r <= len2_c_r;
      vv_d_r   <= vv_c_r;
      ww_d_r   <= ww_c_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mag
    always_ff @(posedge clk) begin
      if (en) begin
        xm_d_r[i] <= xs_c_r[i][PW] ? XW'(-xs_c_r[i]) : XW'(xs_c_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage e
  // classify, and split squares of the cross components
  logic              e_vld_r;
  psd3_pkg::ctl_t    ctl_e_nxt;
  psd3_pkg::ctl_t    ctl_e_r;
  logic [2*HB-1:0]   hh_e_r [3];
  logic [HB+LB-1:0]  hl_e_r [3];
  logic [2*LB-1:0]   ll_e_r [3];

  always_comb begin
    ctl_e_nxt.len2  = len2_d_r;
    ctl_e_nxt.dneg  = dneg_d_r;
    ctl_e_nxt.degen = (len2_d_r == '0);
    ctl_e_nxt.tnum  = {dotm_d_r, {FB{1'b0}}};
    ctl_e_nxt.tovf  = ({{TSH{1'b0}}, dotm_d_r} >= OVW'({len2_d_r, {TSH{1'b0}}}));
    priority if (len2_d_r == '0) begin
      ctl_e_nxt.region = psd3_pkg::REGION_INTERIOR;
    end else if (dneg_d_r && (dotm_d_r != '0)) begin
      ctl_e_nxt.region = psd3_pkg::REGION_BEFORE;
    end else if (!dneg_d_r && (dotm_d_r > len2_d_r)) begin
      ctl_e_nxt.region = psd3_pkg::REGION_BEYOND;
    end else begin
      ctl_e_nxt.region = psd3_pkg::REGION_INTERIOR;
    end
    ctl_e_nxt.use_perp = (len2_d_r != '0) &&
                         (ctl_e_nxt.region == psd3_pkg::REGION_INTERIOR);
    ctl_e_nxt.alt = (ctl_e_nxt.region == psd3_pkg::REGION_BEYOND) ? ww_d_r : vv_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_e_r <= ctl_e_nxt;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_part
    always_ff @(posedge clk) begin
      if (en) begin
        hh_e_r[i] <= xm_d_r[i][XW-1:LB] * xm_d_r[i][XW-1:LB];
        hl_e_r[i] <= xm_d_r[i][XW-1:LB] * xm_d_r[i][LB-1:0];
        ll_e_r[i] <= xm_d_r[i][LB-1:0] * xm_d_r[i][LB-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- stage f
  // squares of the cross components
  logic           f_vld_r;
  psd3_pkg::ctl_t ctl_f_r;
  logic [PRW-1:0] sq_f_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_f_r <= ctl_e_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq_f_r[i] <= (PRW'(hh_e_r[i]) << (2*LB)) + (PRW'(hl_e_r[i]) << (LB+1)) +
                     PRW'(ll_e_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage g
  // squared cross norm, load the divider
  logic [NDIV:0]   dv_vld_r;
  psd3_pkg::div_t  dv_r   [NDIV+1];
  psd3_pkg::div_t  dv_nxt [NDIV];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else if (en) begin
      dv_vld_r <= {dv_vld_r[NDIV-1:0], f_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0].prem     <= sq_f_r[0] + sq_f_r[1] + sq_f_r[2];
      dv_r[0].pq       <= '0;
      dv_r[0].trem     <= ctl_f_r.tnum;
      dv_r[0].tq       <= '0;
      dv_r[0].len2     <= ctl_f_r.len2;
      dv_r[0].alt      <= ctl_f_r.alt;
      dv_r[0].use_perp <= ctl_f_r.use_perp;
      dv_r[0].dneg     <= ctl_f_r.dneg;
      dv_r[0].tovf     <= ctl_f_r.tovf;
      dv_r[0].region   <= ctl_f_r.region;
      dv_r[0].degen    <= ctl_f_r.degen;
    end
  end

  // ---------------------------------------------------------------- divider
  // one quotient bit per stage for perp / len2, and for t in the low steps
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [PRW:0] pd;
    assign pd = {{(PRW+1-SQW){1'b0}}, dv_r[j].len2} << K;

    if (K < TW) begin : g_tbit
      logic [TCW-1:0] td;
      assign td = {{(TCW-SQW){1'b0}}, dv_r[j].len2} << K;
      always_comb begin
        dv_nxt[j] = dv_r[j];
        if ({1'b0, dv_r[j].prem} >= pd) begin
          dv_nxt[j].prem  = dv_r[j].prem - pd[PRW-1:0];
          dv_nxt[j].pq[K] = 1'b1;
        end
        if ({{(TCW-TNW){1'b0}}, dv_r[j].trem} >= td) begin
          dv_nxt[j].trem  = dv_r[j].trem - td[TNW-1:0];
          dv_nxt[j].tq[K] = 1'b1;
        end
      end
    end else begin : g_pbit
      always_comb begin
        dv_nxt[j] = dv_r[j];
        if ({1'b0, dv_r[j].prem} >= pd) begin
          dv_nxt[j].prem  = dv_r[j].prem - pd[PRW-1:0];
          dv_nxt[j].pq[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j+1] <= dv_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------- root
  // pick the squared distance, then one root bit per stage
  logic [RB:0]     sr_vld_r;
  psd3_pkg::sqr_t  sr_r   [RB+1];
  psd3_pkg::sqr_t  sr_nxt [RB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_vld_r <= '0;
    end else if (en) begin
      sr_vld_r <= {sr_vld_r[RB-1:0], dv_vld_r[NDIV]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0].rem    <= RMW'(dv_r[NDIV].use_perp ? dv_r[NDIV].pq : dv_r[NDIV].alt);
      sr_r[0].root   <= '0;
      sr_r[0].tq     <= dv_r[NDIV].tq;
      sr_r[0].dneg   <= dv_r[NDIV].dneg;
      sr_r[0].tovf   <= dv_r[NDIV].tovf;
      sr_r[0].region <= dv_r[NDIV].region;
      sr_r[0].degen  <= dv_r[NDIV].degen;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_root
    localparam int B = RB - 1 - j;
    logic [RMW-1:0] trial;
    // (r + 2^b)^2 - r^2
    assign trial = (RMW'(sr_r[j].root) << (B+1)) + (RMW'(1) << (2*B));
    always_comb begin
      sr_nxt[j] = sr_r[j];
      if (sr_r[j].rem >= trial) begin
        sr_nxt[j].rem     = sr_r[j].rem - trial;
        sr_nxt[j].root[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sr_r[j+1] <= sr_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------- output
  // saturate and sign t, register the result
  logic [TW-1:0] t_nxt;

  always_comb begin
    priority if (sr_r[RB].degen) begin
      t_nxt = '0;
    end else if (sr_r[RB].dneg) begin
      if (sr_r[RB].tovf || (sr_r[RB].tq > psd3_pkg::T_NEG_MAG)) begin
        t_nxt = -psd3_pkg::T_NEG_MAG;
      end else begin
        t_nxt = -sr_r[RB].tq;
      end
    end else if (sr_r[RB].tovf || sr_r[RB].tq[TW-1]) begin
      t_nxt = psd3_pkg::T_MAX;
    end else begin
      t_nxt = sr_r[RB].tq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sr_vld_r[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r   <= DW'(sr_r[RB].root);
      t_r      <= t_nxt;
      region_r <= sr_r[RB].region;
      degen_r  <= sr_r[RB].degen;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(psd3_pkg::OUT_TDATA_W-psd3_pkg::OUT_W){1'b0}}, t_r, dist_r};
  assign out_tuser  = {degen_r, region_r};

endmodule

`default_nettype wire

// File: rtl/core/psd3_checker.sv
// ----------------------------------------------------------------------------
// psd3_checker
// port level checks of the point to segment distance core
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_segment_distance_3d_core_macros.svh"

module psd3_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [psd3_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [psd3_pkg::OUT_TUSER_W-1:0] out_tuser
);

  logic [psd3_pkg::T_WIDTH-1:0]                          chk_t;
  logic [1:0]                                            chk_region;
  logic                                                  chk_degen;
  logic [psd3_pkg::OUT_TDATA_W+psd3_pkg::OUT_TUSER_W-1:0] chk_out;
  logic                                                  chk_interior;
  logic                                                  chk_before;
  logic                                                  chk_beyond;
  logic                                                  chk_t_ge_one;

  assign chk_t        = out_tdata[psd3_pkg::DIST_WIDTH +: psd3_pkg::T_WIDTH];
  assign chk_region   = out_tuser[1:0];
  assign chk_degen    = out_tuser[2];
  assign chk_out      = {out_tuser, out_tdata};
  assign chk_interior = (chk_region == psd3_pkg::REGION_INTERIOR);
  assign chk_before   = (chk_region == psd3_pkg::REGION_BEFORE);
  assign chk_beyond   = (chk_region == psd3_pkg::REGION_BEYOND);
  assign chk_t_ge_one = (chk_t[psd3_pkg::T_WIDTH-2:psd3_pkg::FRAC_BITS] != '0);

  // no result right after reset
  `PSD3_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid)

  // held result stays put
  `PSD3_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(chk_out))

  // zero length segment reports t of zero, interior
  `PSD3_ASSERT(a_degen, out_tvalid && chk_degen |-> chk_t == '0 && chk_interior)

  // beyond the end means t of at least one
  `PSD3_ASSERT(a_beyond, out_tvalid && chk_beyond |-> !chk_t[psd3_pkg::T_WIDTH-1] && chk_t_ge_one)

  // before the start means t not positive
  `PSD3_ASSERT(a_before, out_tvalid && chk_before |-> chk_t[psd3_pkg::T_WIDTH-1] || chk_t == '0)

endmodule

bind point_segment_distance_3d_core psd3_checker u_psd3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
